// ===== rtl/core/lfr_pkg.sv =====
// Shared types, constants and helpers for the latest-frame ring.
// Used by lfr_ctrl, lfr_dp and latest_frame_ring_unit; depends on nothing.
package lfr_pkg;

	localparam int RING_DEPTH = 4;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int OP_W       = 3;
	localparam int KIND_W     = 2;
	localparam int HANDLE_W   = 32;
	localparam int STAMP_W    = 64;
	localparam int CTR_W      = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUBLISH     = 3'd0,
		OP_PEEK        = 3'd1,
		OP_TAKE_NEWEST = 3'd2,
		OP_TAKE_OLDEST = 3'd3,
		OP_FLUSH       = 3'd4,
		OP_STATS       = 3'd5
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACK   = 2'd0,
		KIND_FRAME = 2'd1,
		KIND_DROP  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_PUBLISH,
		UPD_TAKE_NEWEST,
		UPD_TAKE_OLDEST,
		UPD_FLUSH
	} upd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;
		upd_t  upd;
		cnt_t  rd_off;
		logic  emit;
		idx_t  step;
		kind_t kind;
		logic  last;
		logic  wr;
	} cmd_t;

	// Ring status seen by the controller when it decodes an item.
	typedef struct packed {
		cnt_t fill;
		logic empty;
		logic full;
		logic null_handle;
	} status_t;

	// Slot that lies off entries after base, modulo the ring depth.
	// Both inputs stay below the depth plus one, so one subtract suffices.
	function automatic idx_t slot(idx_t base, cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(RING_DEPTH)) begin
			sum = sum - (CNT_W+1)'(RING_DEPTH);
		end
		return idx_t'(sum);
	endfunction

endpackage

// ===== rtl/core/lfr_ctrl.sv =====
// Controller of the latest-frame ring: decodes an item and sequences its results.
// Depends on lfr_pkg for the command, status and state types.
module lfr_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lfr_pkg::OP_W-1:0]       op,
	input  lfr_pkg::status_t               st,
	output lfr_pkg::cmd_t                  cmd,
	output logic                           busy
);

	lfr_pkg::state_t state_q, state_d;
	lfr_pkg::idx_t   step_q;
	lfr_pkg::cnt_t   nres_q;
	lfr_pkg::kind_t  last_kind_q;
	logic            wr_q;

	lfr_pkg::cnt_t   nres_p;
	lfr_pkg::kind_t  last_kind_p;
	lfr_pkg::cnt_t   rd_off_p;
	lfr_pkg::upd_t   upd_p;
	logic            wr_p;
	logic            accept;
	logic            last_step;

	assign accept    = (state_q == lfr_pkg::ST_IDLE) && start;
	assign last_step = (lfr_pkg::CNT_W'(step_q) + lfr_pkg::CNT_W'(1)) == nres_q;

	// Work out how many results the item gives and what the last one is.
	always_comb begin
		nres_p      = lfr_pkg::CNT_W'(1);
		last_kind_p = lfr_pkg::KIND_NONE;
		rd_off_p    = '0;
		upd_p       = lfr_pkg::UPD_NONE;
		wr_p        = 1'b0;
		unique case (op)
			lfr_pkg::OP_PUBLISH: begin
				if (!st.null_handle) begin
					last_kind_p = lfr_pkg::KIND_ACK;
					upd_p       = lfr_pkg::UPD_PUBLISH;
					wr_p        = 1'b1;
					// A full ring first evicts its oldest entry.
					nres_p      = st.full ? lfr_pkg::CNT_W'(2) : lfr_pkg::CNT_W'(1);
				end
			end
			lfr_pkg::OP_STATS: begin
				last_kind_p = lfr_pkg::KIND_ACK;
			end
			lfr_pkg::OP_PEEK: begin
				if (!st.empty) begin
					last_kind_p = lfr_pkg::KIND_FRAME;
					rd_off_p    = st.fill - lfr_pkg::CNT_W'(1);
				end
			end
			lfr_pkg::OP_TAKE_NEWEST: begin
				if (!st.empty) begin
					last_kind_p = lfr_pkg::KIND_FRAME;
					nres_p      = st.fill;
					upd_p       = lfr_pkg::UPD_TAKE_NEWEST;
				end
			end
			lfr_pkg::OP_TAKE_OLDEST: begin
				if (!st.empty) begin
					last_kind_p = lfr_pkg::KIND_FRAME;
					upd_p       = lfr_pkg::UPD_TAKE_OLDEST;
				end
			end
			lfr_pkg::OP_FLUSH: begin
				if (!st.empty) begin
					last_kind_p = lfr_pkg::KIND_DROP;
					nres_p      = st.fill;
					upd_p       = lfr_pkg::UPD_FLUSH;
				end
			end
			default: begin
				last_kind_p = lfr_pkg::KIND_NONE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfr_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lfr_pkg::ST_RUN;
				end
			end
			lfr_pkg::ST_RUN: begin
				if (last_step) begin
					state_d = lfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load   = accept;
		cmd.upd    = upd_p;
		cmd.rd_off = rd_off_p;
		cmd.emit   = (state_q == lfr_pkg::ST_RUN);
		cmd.step   = step_q;
		cmd.kind   = last_step ? last_kind_q : lfr_pkg::KIND_DROP;
		cmd.last   = last_step;
		cmd.wr     = (state_q == lfr_pkg::ST_RUN) && last_step && wr_q;
		busy       = (state_q == lfr_pkg::ST_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfr_pkg::ST_IDLE;
			step_q      <= '0;
			nres_q      <= lfr_pkg::CNT_W'(1);
			last_kind_q <= lfr_pkg::KIND_NONE;
			wr_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q      <= '0;
				nres_q      <= nres_p;
				last_kind_q <= last_kind_p;
				wr_q        <= wr_p;
			end else if (state_q == lfr_pkg::ST_RUN && !last_step) begin
				step_q <= step_q + lfr_pkg::IDX_W'(1);
			end
		end
	end

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfr_pkg::ST_RUN) |-> (lfr_pkg::CNT_W'(step_q) < nres_q))
		else $error("result step ran past the result count");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == lfr_pkg::ST_RUN && step_q == '0))
		else $error("accepted item did not start its result sequence");

	a_write_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (cmd.last && cmd.kind == lfr_pkg::KIND_ACK))
		else $error("store write outside the final publish result");

endmodule

// ===== rtl/core/lfr_dp.sv =====
// Datapath of the latest-frame ring: entry stores, ring pointers, counters
// and the registered result outputs. Depends on lfr_pkg.
module lfr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfr_pkg::cmd_t                      cmd,
	input  logic [lfr_pkg::HANDLE_W-1:0]       frame_handle,
	input  logic [lfr_pkg::STAMP_W-1:0]        time_stamp,
	output lfr_pkg::status_t                   st,
	output logic                               strobe,
	output logic [lfr_pkg::KIND_W-1:0]         kind,
	output logic [lfr_pkg::HANDLE_W-1:0]       out_handle,
	output logic [lfr_pkg::STAMP_W-1:0]        out_stamp,
	output logic                               last,
	output logic [lfr_pkg::CTR_W-1:0]          produced_count,
	output logic [lfr_pkg::CTR_W-1:0]          dropped_count,
	output logic [lfr_pkg::CTR_W-1:0]          consumed_count,
	output logic [lfr_pkg::CNT_W-1:0]          held_count
);

	logic [lfr_pkg::HANDLE_W-1:0] handle_mem_q [lfr_pkg::RING_DEPTH];
	logic [lfr_pkg::STAMP_W-1:0]  stamp_mem_q  [lfr_pkg::RING_DEPTH];

	lfr_pkg::idx_t                oldest_q;
	lfr_pkg::cnt_t                fill_q;
	logic [lfr_pkg::CTR_W-1:0]    produced_q;
	logic [lfr_pkg::CTR_W-1:0]    dropped_q;
	logic [lfr_pkg::CTR_W-1:0]    consumed_q;

	lfr_pkg::idx_t                base_q;
	lfr_pkg::idx_t                wr_idx_q;
	logic [lfr_pkg::HANDLE_W-1:0] new_handle_q;
	logic [lfr_pkg::STAMP_W-1:0]  new_stamp_q;

	logic                         strobe_q;
	lfr_pkg::kind_t               kind_q;
	logic [lfr_pkg::HANDLE_W-1:0] out_handle_q;
	logic [lfr_pkg::STAMP_W-1:0]  out_stamp_q;
	logic                         last_q;

	lfr_pkg::idx_t                rd_idx;
	logic                         has_data;

	assign st.fill        = fill_q;
	assign st.empty       = (fill_q == '0);
	assign st.full        = (fill_q == lfr_pkg::CNT_W'(lfr_pkg::RING_DEPTH));
	assign st.null_handle = (frame_handle == '0);

	assign rd_idx   = lfr_pkg::slot(base_q, lfr_pkg::CNT_W'(cmd.step));
	assign has_data = (cmd.kind == lfr_pkg::KIND_FRAME) || (cmd.kind == lfr_pkg::KIND_DROP);

	// The new entry is written with the final result, after any eviction read.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			handle_mem_q[wr_idx_q] <= new_handle_q;
			stamp_mem_q[wr_idx_q]  <= new_stamp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q       <= lfr_pkg::slot(oldest_q, cmd.rd_off);
			wr_idx_q     <= lfr_pkg::slot(oldest_q, fill_q);
			new_handle_q <= frame_handle;
			new_stamp_q  <= time_stamp;
		end
		if (cmd.emit) begin
			kind_q       <= cmd.kind;
			last_q       <= cmd.last;
			out_handle_q <= has_data ? handle_mem_q[rd_idx] : '0;
			out_stamp_q  <= has_data ? stamp_mem_q[rd_idx] : '0;
		end
	end

	// Ring pointers and counters jump to their final values when the item
	// is accepted, so every result of the item reports the same totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			fill_q     <= '0;
			produced_q <= '0;
			dropped_q  <= '0;
			consumed_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				case (cmd.upd)
					lfr_pkg::UPD_PUBLISH: begin
						produced_q <= produced_q + lfr_pkg::CTR_W'(1);
						if (st.full) begin
							dropped_q <= dropped_q + lfr_pkg::CTR_W'(1);
							oldest_q  <= lfr_pkg::slot(oldest_q, lfr_pkg::CNT_W'(1));
						end else begin
							fill_q <= fill_q + lfr_pkg::CNT_W'(1);
						end
					end
					lfr_pkg::UPD_TAKE_NEWEST: begin
						dropped_q  <= dropped_q + lfr_pkg::CTR_W'(fill_q) - lfr_pkg::CTR_W'(1);
						consumed_q <= consumed_q + lfr_pkg::CTR_W'(1);
						fill_q     <= '0;
						oldest_q   <= '0;
					end
					lfr_pkg::UPD_TAKE_OLDEST: begin
						consumed_q <= consumed_q + lfr_pkg::CTR_W'(1);
						fill_q     <= fill_q - lfr_pkg::CNT_W'(1);
						if (fill_q == lfr_pkg::CNT_W'(1)) begin
							oldest_q <= '0;
						end else begin
							oldest_q <= lfr_pkg::slot(oldest_q, lfr_pkg::CNT_W'(1));
						end
					end
					lfr_pkg::UPD_FLUSH: begin
						dropped_q <= dropped_q + lfr_pkg::CTR_W'(fill_q);
						fill_q    <= '0;
						oldest_q  <= '0;
					end
					default: begin
						fill_q <= fill_q;
					end
				endcase
			end
		end
	end

	assign strobe         = strobe_q;
	assign kind           = kind_q;
	assign out_handle     = out_handle_q;
	assign out_stamp      = out_stamp_q;
	assign last           = last_q;
	assign produced_count = produced_q;
	assign dropped_count  = dropped_q;
	assign consumed_count = consumed_q;
	assign held_count     = fill_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lfr_pkg::CNT_W'(lfr_pkg::RING_DEPTH))
		else $error("ring fill level above depth");

	a_emptied: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (cmd.upd == lfr_pkg::UPD_FLUSH || cmd.upd == lfr_pkg::UPD_TAKE_NEWEST))
		|=> (fill_q == '0 && oldest_q == '0))
		else $error("ring not empty after flush or take newest");

endmodule

// ===== rtl/core/latest_frame_ring_unit.sv =====
// Latest-frame ring: keeps the newest RING_DEPTH frame handles and stamps.
// An item is accepted when start is high and busy is low; busy then stays
// high while the item's results, 1 to RING_DEPTH of them, are emitted one
// result per cycle; each leaves the output register in the next cycle. The
// sequencer emits one entry per cycle through a single store read port.
// Reset clears counters and pointers; stores hold no reset.
module latest_frame_ring_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [lfr_pkg::OP_W-1:0]           op,
	input  logic [lfr_pkg::HANDLE_W-1:0]       frame_handle,
	input  logic [lfr_pkg::STAMP_W-1:0]        time_stamp,
	output logic                               strobe,
	output logic [lfr_pkg::KIND_W-1:0]         kind,
	output logic [lfr_pkg::HANDLE_W-1:0]       out_handle,
	output logic [lfr_pkg::STAMP_W-1:0]        out_stamp,
	output logic                               last,
	output logic [lfr_pkg::CTR_W-1:0]          produced_count,
	output logic [lfr_pkg::CTR_W-1:0]          dropped_count,
	output logic [lfr_pkg::CTR_W-1:0]          consumed_count,
	output logic [lfr_pkg::CNT_W-1:0]          held_count
);

	lfr_pkg::cmd_t    cmd;
	lfr_pkg::status_t st;

	lfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	lfr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.frame_handle   (frame_handle),
		.time_stamp     (time_stamp),
		.st             (st),
		.strobe         (strobe),
		.kind           (kind),
		.out_handle     (out_handle),
		.out_stamp      (out_stamp),
		.last           (last),
		.produced_count (produced_count),
		.dropped_count  (dropped_count),
		.consumed_count (consumed_count),
		.held_count     (held_count)
	);

endmodule
